// ===== rtl/core/s2rd_pkg.sv =====
`default_nettype none

package s2rd_pkg;

  // Field and register widths
  localparam int NumW    = 32;
  localparam int CharW   = 8;
  localparam int RadixW  = 5;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 64;

  // Digit alphabet: up to sixteen characters, one byte each
  localparam int MaxRadix   = 16;
  localparam int AlphaChars = 16;
  localparam int DigitW     = 4;
  localparam int AlphaW     = AlphaChars * CharW;

  // Digit stack: enough for the binary text of 2^31
  localparam int MaxDigits = 32;
  localparam int StkW      = MaxDigits * DigitW;
  localparam int CntW      = $clog2(MaxDigits + 1);

  // Division unit: dividend bits retired per cycle
  localparam int DivBits  = 8;
  localparam int DivSteps = NumW / DivBits;
  localparam int StepW    = $clog2(DivSteps);

  // Request queue between front and back (power of two)
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [CharW-1:0] CharPlus  = 8'd43;
  localparam logic [CharW-1:0] CharMinus = 8'd45;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RADIX        = 2'd0,
    CFG_DIGITS_LOWER = 2'd1,
    CFG_DIGITS_UPPER = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic [RadixW-1:0] radix;
    logic [AlphaW-1:0] alphabet;
  } cfg_t;

  typedef struct packed {
    logic            neg;
    logic [NumW-1:0] mag;
  } item_t;

  function automatic logic [CharW-1:0] digit_char(input logic [AlphaW-1:0] alphabet,
                                                  input logic [DigitW-1:0] k);
    return alphabet[{k, 3'b000} +: CharW];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/s2rd_if.sv =====
`default_nettype none

interface s2rd_num_if import s2rd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [NumW-1:0] number;

  modport source(output valid, output number, input ready);
  modport sink(input valid, input number, output ready);
endinterface

interface s2rd_text_if import s2rd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;
  logic             is_last;

  modport source(output valid, output character, output is_last, input ready);
  modport sink(input valid, input character, input is_last, output ready);
endinterface

interface s2rd_cfg_if import s2rd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/s2rd_front.sv =====
`default_nettype none

module s2rd_front import s2rd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  s2rd_cfg_if.sink    cfg,
  s2rd_num_if.sink    num,
  input  wire logic   q_full,
  output logic        push,
  output item_t       push_item,
  output cfg_t        cfg_set
);

  logic [RadixW-1:0] radix;
  logic [CfgW-1:0]   digits_lower;
  logic [CfgW-1:0]   digits_upper;
  logic              cfg_dirty;
  logic              alpha_ok;
  logic              alpha_ok_next;
  logic [AlphaW-1:0] alphabet;
  logic [CharW-1:0]  c;
  logic              accept;

  assign alphabet = {digits_upper, digits_lower};
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix        <= '0;
      digits_lower <= '0;
      digits_upper <= '0;
      cfg_dirty    <= 1'b0;
      alpha_ok     <= 1'b0;
    end else begin
      cfg_dirty <= cfg.valid;
      alpha_ok  <= alpha_ok_next;
      if (cfg.valid) begin
        unique case (cfg_idx_t'(cfg.index))
          CFG_RADIX:        radix        <= cfg.data[RadixW-1:0];
          CFG_DIGITS_LOWER: digits_lower <= cfg.data;
          CFG_DIGITS_UPPER: digits_upper <= cfg.data;
          default: ;
        endcase
      end
    end
  end

  // alphabet check: base in range, no zero or sign byte, no repeats among live digits
  always_comb begin
    alpha_ok_next = (radix >= RadixW'(2)) && (radix <= RadixW'(MaxRadix));
    c = '0;
    for (int a = 0; a < AlphaChars; a++) begin
      if (RadixW'(a) < radix) begin
        c = digit_char(alphabet, DigitW'(a));
        if (c == '0 || c == CharPlus || c == CharMinus) alpha_ok_next = 1'b0;
        for (int b = a + 1; b < AlphaChars; b++) begin
          if (RadixW'(b) < radix && digit_char(alphabet, DigitW'(b)) == c)
            alpha_ok_next = 1'b0;
        end
      end
    end
  end

  // hold off while cfg_dirty marks a fresh write, so the check has caught up
  assign num.ready = !q_full && !cfg_dirty;
  assign accept    = num.valid && num.ready;
  assign push      = accept && alpha_ok;

  assign push_item.neg = num.number[NumW-1];
  assign push_item.mag = num.number[NumW-1] ? (NumW'(0) - NumW'(num.number))
                                            : NumW'(num.number);

  assign cfg_set.radix    = radix;
  assign cfg_set.alphabet = alphabet;

endmodule

`default_nettype wire

// ===== rtl/core/s2rd_queue.sv =====
`default_nettype none

module s2rd_queue import s2rd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  item_t      wr_item,
  output logic       full,
  input  wire logic  pop,
  output logic       empty,
  output item_t      rd_item
);

  item_t             slots [QDepth];
  logic [QPtrW-1:0]  wr_ptr;
  logic [QPtrW-1:0]  rd_ptr;
  logic [QCntW-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCntW'(QDepth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/s2rd_back.sv =====
`default_nettype none

module s2rd_back import s2rd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  cfg_t        cfg_set,
  input  wire logic   empty,
  input  item_t       rd_item,
  output logic        pop,
  s2rd_text_if.source text
);

  back_state_t       state, state_next;
  logic [NumW-1:0]   quo, quo_next;
  logic [DigitW-1:0] rem_r, rem_next;
  logic [StepW-1:0]  step, step_next;
  logic [StkW-1:0]   stk, stk_next;
  logic [CntW-1:0]   nd, nd_next;
  logic              minus_pend, minus_next;
  logic              out_valid, ov_next;
  logic [CharW-1:0]  out_char, oc_next;
  logic              out_last, ol_next;
  logic              out_load;

  logic [RadixW-1:0]  r;
  logic [DivBits-1:0] qb;
  logic [NumW-1:0]    quo_div;

  // restoring division, one dividend byte a cycle
  always_comb begin
    r  = {1'b0, rem_r};
    qb = '0;
    for (int i = 0; i < DivBits; i++) begin
      r = {r[DigitW-1:0], quo[NumW-1-i]};
      if (r >= cfg_set.radix) begin
        qb[DivBits-1-i] = 1'b1;
        r = r - cfg_set.radix;
      end
    end
    quo_div = {quo[NumW-DivBits-1:0], qb};
  end

  assign out_load = !out_valid || text.ready;

  always_comb begin
    state_next = state;
    quo_next   = quo;
    rem_next   = rem_r;
    step_next  = step;
    stk_next   = stk;
    nd_next    = nd;
    minus_next = minus_pend;
    ov_next    = out_valid && !text.ready;
    oc_next    = out_char;
    ol_next    = out_last;
    pop        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          quo_next   = rd_item.mag;
          minus_next = rd_item.neg;
          rem_next   = '0;
          step_next  = '0;
          nd_next    = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_next  = quo_div;
        rem_next  = r[DigitW-1:0];
        step_next = step + 1'b1;
        if (step == StepW'(DivSteps - 1)) begin
          // digit done: push remainder, go again on a nonzero quotient, else emit
          stk_next = {stk[StkW-DigitW-1:0], r[DigitW-1:0]};
          nd_next  = nd + 1'b1;
          rem_next = '0;
          if (quo_div == '0) state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          ov_next = 1'b1;
          if (minus_pend) begin
            oc_next    = CharMinus;
            ol_next    = 1'b0;
            minus_next = 1'b0;
          end else begin
            oc_next  = digit_char(cfg_set.alphabet, stk[DigitW-1:0]);
            ol_next  = (nd == CntW'(1));
            stk_next = stk >> DigitW;
            nd_next  = nd - 1'b1;
            if (nd == CntW'(1)) state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      nd         <= '0;
      minus_pend <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      nd         <= nd_next;
      minus_pend <= minus_next;
      out_valid  <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    quo      <= quo_next;
    rem_r    <= rem_next;
    step     <= step_next;
    stk      <= stk_next;
    out_char <= oc_next;
    out_last <= ol_next;
  end

  assign text.valid     = out_valid;
  assign text.character = out_char;
  assign text.is_last   = out_last;

  a_emit_has_digits: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> nd != '0)
    else $error("emit with empty digit stack");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> {1'b0, rem_r} < cfg_set.radix)
    else $error("partial remainder not below radix");

  a_valid_radix: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> cfg_set.radix >= RadixW'(2))
    else $error("conversion running with invalid radix");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    nd <= CntW'(MaxDigits))
    else $error("digit stack overflow");

endmodule

`default_nettype wire

// ===== rtl/core/signed_integer_to_radix_digits.sv =====
// A number passes through the queue, is popped by the idle back end, divided digit by digit
// in the byte-a-cycle division loop, then emitted MSB first, after a minus sign if negative.
// The back end converts one number at a time; the two-entry queue holds more meanwhile.
// Invalid alphabets drop the request in the front end, producing nothing.
// Reset (rst, synchronous, active high) clears config to zero, empties the queue, idles.
`default_nettype none

module signed_integer_to_radix_digits import s2rd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  s2rd_cfg_if.sink    cfg,
  s2rd_num_if.sink    num,
  s2rd_text_if.source text
);

  // front end: config registers, alphabet check, sign/magnitude split
  cfg_t  cfg_set;
  item_t push_item;
  item_t rd_item;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_empty;

  s2rd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .num       (num),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item),
    .cfg_set   (cfg_set)
  );

  // two-entry queue decouples acceptance from conversion
  s2rd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (push_item),
    .full    (q_full),
    .pop     (pop),
    .empty   (q_empty),
    .rd_item (rd_item)
  );

  // back end: repeated division into a digit stack, then MSB-first emit
  // through a registered output stage
  s2rd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg_set (cfg_set),
    .empty   (q_empty),
    .rd_item (rd_item),
    .pop     (pop),
    .text    (text)
  );

endmodule

`default_nettype wire

// ===== tb/signed_integer_to_radix_digits_tb.sv =====
`timescale 1ns / 100ps

module signed_integer_to_radix_digits_tb import s2rd_pkg::*; ();

  // Run control
  localparam int RandomItems  = 415;  // numbers under a legal alphabet
  localparam int CalmItems    = 40;   // last numbers go out with no idling
  localparam int SettleCycles = 200;  // > binary worst case of one number
  localparam int CycleLimit   = 1000000;

  // Index with no register behind it; the write must be dropped
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED = 2'd3;

  // One queued request: a register write or a number to convert
  typedef struct {
    bit                     is_write;
    logic [CfgIdxW-1:0]     index;
    logic [CfgW-1:0]        data;
    logic signed [NumW-1:0] number;
  } request_t;

  // One expected output character
  typedef struct packed {
    logic [CharW-1:0] character;
    logic             is_last;
  } text_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  s2rd_cfg_if  cfg_bus  ();
  s2rd_num_if  num_bus  ();
  s2rd_text_if text_bus ();

  signed_integer_to_radix_digits dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_bus),
    .num  (num_bus),
    .text (text_bus)
  );

  // Requests waiting to go out, and characters still owed by the block
  request_t   request_q [$];
  text_beat_t text_due  [$];

  int errors       = 0;
  int nums_waiting = 0;   // numbers still in request_q
  int cycles       = 0;
  int settle       = 0;   // cycles the block has been quiet
  int send_gap     = 0;   // sender idle burst left
  int stall        = 0;   // receiver stall burst left
  logic calm       = 1'b0;

  // Our copy of the register file
  logic [RadixW-1:0] radix_now;
  logic [CfgW-1:0]   glyphs_lo;
  logic [CfgW-1:0]   glyphs_hi;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  function automatic void apply_write(input logic [CfgIdxW-1:0] index,
                                      input logic [CfgW-1:0] data);
    case (index)
      CFG_RADIX:        radix_now = data[RadixW-1:0];
      CFG_DIGITS_LOWER: glyphs_lo = data;
      CFG_DIGITS_UPPER: glyphs_hi = data;
      default: ;        // unmapped index, no effect
    endcase
  endfunction

  // Queue the text of one number under the current alphabet.
  // An illegal alphabet yields no characters at all.
  function automatic void predict_text(input logic signed [NumW-1:0] value);
    logic [2*CfgW-1:0] glyphs;
    logic [NumW-1:0]   mag;
    logic [NumW-1:0]   base;
    logic [CharW-1:0]  c;
    int                digit [MaxDigits];
    int                nd;
    bit                legal;
    glyphs = {glyphs_hi, glyphs_lo};
    base   = NumW'(radix_now);
    legal  = (base >= 2) && (base <= MaxRadix);
    for (int a = 0; a < int'(base) && legal; a++) begin
      c = glyphs[8*a +: CharW];
      if (c == '0 || c == CharPlus || c == CharMinus)
        legal = 1'b0;
      for (int b = a + 1; b < int'(base); b++)
        if (glyphs[8*b +: CharW] == c)
          legal = 1'b0;
    end
    if (!legal)
      return;
    // two's complement negate; the most negative value maps to 2^31 unsigned
    mag = value;
    if (value[NumW-1])
      mag = ~mag + 1'b1;
    nd = 0;
    do begin
      digit[nd] = int'(mag % base);
      nd++;
      mag = mag / base;
    end while (mag != 0 && nd < MaxDigits);
    if (value[NumW-1])
      text_due.push_back('{character: CharMinus, is_last: 1'b0});
    for (int k = nd - 1; k >= 0; k--)
      text_due.push_back('{character: glyphs[8*digit[k] +: CharW], is_last: (k == 0)});
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  function automatic void add_write(input logic [CfgIdxW-1:0] index,
                                    input logic [CfgW-1:0] data);
    request_q.push_back('{is_write: 1'b1, index: index, data: data, number: '0});
  endfunction

  function automatic void add_num(input logic signed [NumW-1:0] value);
    request_q.push_back('{is_write: 1'b0, index: '0, data: '0, number: value});
    nums_waiting++;
  endfunction

  function automatic void queue_alphabet(input logic [CfgW-1:0] radix_data,
                                         input logic [2*CfgW-1:0] glyphs);
    add_write(CFG_RADIX, radix_data);
    add_write(CFG_DIGITS_LOWER, glyphs[CfgW-1:0]);
    add_write(CFG_DIGITS_UPPER, glyphs[2*CfgW-1:CfgW]);
  endfunction

  // Pack a string into the digit registers, byte 0 first; the rest is zero
  function automatic logic [2*CfgW-1:0] glyphs_of(input string s);
    logic [2*CfgW-1:0] g;
    g = '0;
    for (int i = 0; i < s.len(); i++)
      g[8*i +: CharW] = s[i];
    return g;
  endfunction

  // Distinct legal digit bytes; unused bytes are arbitrary, zero and signs too
  function automatic logic [2*CfgW-1:0] random_glyphs(input int base);
    logic [2*CfgW-1:0] g;
    logic [CharW-1:0]  c;
    bit                clash;
    g = {$urandom, $urandom, $urandom, $urandom};
    for (int k = 0; k < base; k++) begin
      do begin
        c     = CharW'($urandom_range(1, 255));
        clash = (c == CharPlus) || (c == CharMinus);
        for (int j = 0; j < k; j++)
          if (g[8*j +: CharW] == c)
            clash = 1'b1;
      end while (clash);
      g[8*k +: CharW] = c;
    end
    return g;
  endfunction

  // Mix of full-range values, small values, powers of the base and extremes
  function automatic logic signed [NumW-1:0] random_number(input int base);
    logic [NumW-1:0] p;
    int              k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5: begin
        p = $urandom_range(0, 300);
        return $urandom_range(0, 1) ? -p : p;
      end
      6, 7: begin
        // around base^k, which flips the digit count
        p = 1;
        k = $urandom_range(1, 31);
        repeat (k)
          if (p <= 32'h7FFF_FFFF / base)
            p = p * base;
        p = p + $urandom_range(0, 2) - 1;
        return $urandom_range(0, 1) ? -p : p;
      end
      8: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 0;
          default: return -1;
        endcase
      end
      default: return 32'h8000_0000 + $urandom_range(0, 1000);
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus: directed part, then random phases, then wait out the tail
  // -------------------------------------------------------------------------

  initial begin : stimulus
    logic [2*CfgW-1:0] glyphs;
    logic [CfgW-1:0]   radix_data;
    int                base;
    int                count;
    int                phase;
    int                legal_items;
    int                a;
    int                b;
    bit                broken;

    // registers still at reset: radix 0, nothing comes out
    add_num(5);

    // decimal: zero, one, signs, both ends of the range, digit-count step
    queue_alphabet(64'd10, glyphs_of("0123456789"));
    add_num(0);
    add_num(1);
    add_num(-1);
    add_num(32'h7FFF_FFFF);
    add_num(32'h8000_0000);
    add_num(10);
    add_num(-10);

    // hex, widest radix; upper radix bits set and masked off
    queue_alphabet(64'hFFFF_FFFF_FFFF_FFF0, glyphs_of("0123456789ABCDEF"));
    add_num(32'h8000_0000);
    add_num(32'h7FFF_FFFF);
    add_num(-1);

    // binary, narrowest radix: most negative value gives 33 characters
    queue_alphabet(64'd2, glyphs_of("01"));
    add_num(32'h8000_0000);
    add_num(0);
    add_num(32'h7FFF_FFFF);

    // bytes past the radix hold signs, a zero and a repeat: all ignored
    queue_alphabet(64'd3, glyphs_of("xyz-+x"));
    add_num(-5);
    add_num(26);

    // write to an unmapped index changes nothing
    add_write(CFG_UNMAPPED, '1);
    add_num(-7);

    // radix out of range on both sides
    add_write(CFG_RADIX, 64'd1);
    add_num(3);
    add_write(CFG_RADIX, 64'd0);
    add_num(3);
    add_write(CFG_RADIX, 64'd17);
    add_num(3);
    add_write(CFG_RADIX, 64'd31);
    add_num(3);

    // broken alphabets: repeat, plus, minus, zero byte
    queue_alphabet(64'd10, glyphs_of("0123456780"));
    add_num(42);
    queue_alphabet(64'd4, glyphs_of("01+3"));
    add_num(42);
    queue_alphabet(64'd4, glyphs_of("ab-d"));
    add_num(42);
    queue_alphabet(64'd3, glyphs_of("ab"));
    add_num(42);

    // random phases: a fresh alphabet each, now and then a broken one
    legal_items = 0;
    phase       = 0;
    while (legal_items < RandomItems) begin
      if (phase == 0)
        base = 2;
      else if (phase == 1)
        base = MaxRadix;
      else
        base = $urandom_range(2, MaxRadix);
      glyphs     = random_glyphs(base);
      radix_data = {$urandom, $urandom};
      radix_data[RadixW-1:0] = RadixW'(base);
      broken = (phase > 1) && ($urandom_range(0, 4) == 0);
      if (broken) begin
        a = $urandom_range(0, base - 2);
        b = $urandom_range(a + 1, base - 1);
        case ($urandom_range(0, 4))
          0: radix_data[RadixW-1:0] = RadixW'($urandom_range(0, 1) ? $urandom_range(0, 1)
                                                                    : $urandom_range(17, 31));
          1: glyphs[8*b +: CharW] = glyphs[8*a +: CharW];
          2: glyphs[8*b +: CharW] = '0;
          3: glyphs[8*a +: CharW] = CharPlus;
          default: glyphs[8*b +: CharW] = CharMinus;
        endcase
      end
      queue_alphabet(radix_data, glyphs);
      count = broken ? $urandom_range(3, 8) : $urandom_range(20, 45);
      repeat (count)
        add_num(random_number(base));
      if (!broken)
        legal_items += count;
      phase++;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // drain: every request out, every character in, then a quiet tail
    while (request_q.size() != 0 || num_bus.valid || cfg_bus.valid ||
           text_due.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Driver: numbers with random idle bursts; writes only once the block is quiet
  // -------------------------------------------------------------------------

  always @(posedge clk) begin : driver
    bit num_hold;
    bit cfg_hold;
    if (rst) begin
      num_bus.valid  <= 1'b0;
      num_bus.number <= '0;
      cfg_bus.valid  <= 1'b0;
      cfg_bus.index  <= '0;
      cfg_bus.data   <= '0;
      send_gap       <= 0;
      calm           <= 1'b0;
    end else begin
      // a request not yet taken stays on the bus unchanged
      num_hold = num_bus.valid && !num_bus.ready;
      cfg_hold = cfg_bus.valid && !cfg_bus.ready;
      if (!num_hold && !cfg_hold && request_q.size() != 0) begin
        if (request_q[0].is_write) begin
          // settle is long enough for a dropped number to clear the block too
          if (settle >= SettleCycles) begin
            cfg_bus.index <= request_q[0].index;
            cfg_bus.data  <= request_q[0].data;
            cfg_hold = 1'b1;
            void'(request_q.pop_front());
          end
        end else if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(0, 3);   // idle now and while send_gap counts down
        end else begin
          num_bus.number <= request_q[0].number;
          num_hold = 1'b1;
          void'(request_q.pop_front());
          nums_waiting--;
        end
      end
      num_bus.valid <= num_hold;
      cfg_bus.valid <= cfg_hold;
      calm          <= (nums_waiting < CalmItems);
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: tracks writes, predicts on each number taken, checks each character
  // -------------------------------------------------------------------------

  always @(posedge clk) begin : monitor
    text_beat_t want;
    if (rst) begin
      radix_now      = '0;
      glyphs_lo      = '0;
      glyphs_hi      = '0;
      text_bus.ready <= 1'b0;
      stall          <= 0;
      settle         <= 0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready)
        apply_write(cfg_bus.index, cfg_bus.data);

      if (text_bus.valid && text_bus.ready) begin
        if (text_due.size() == 0) begin
          $error("character %h (is_last %b) with nothing outstanding",
                 text_bus.character, text_bus.is_last);
          errors++;
        end else begin
          want = text_due.pop_front();
          if (text_bus.character !== want.character) begin
            $error("character: expected %h, got %h", want.character, text_bus.character);
            errors++;
          end
          if (text_bus.is_last !== want.is_last) begin
            $error("is_last: expected %b, got %b", want.is_last, text_bus.is_last);
            errors++;
          end
        end
      end

      if (num_bus.valid && num_bus.ready)
        predict_text(num_bus.number);

      // quiet means no number on offer and nothing owed
      if (num_bus.valid || text_bus.valid || text_due.size() != 0)
        settle <= 0;
      else if (settle < SettleCycles)
        settle <= settle + 1;

      // receiver stalls in random bursts while stall counts down, none near the end
      if (stall > 0) begin
        stall          <= stall - 1;
        text_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall          <= $urandom_range(0, 3);
        text_bus.ready <= 1'b0;
      end else begin
        text_bus.ready <= 1'b1;
      end
    end
  end

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/core/s2rd_pkg.sv
rtl/core/s2rd_if.sv
rtl/core/s2rd_front.sv
rtl/core/s2rd_queue.sv
rtl/core/s2rd_back.sv
rtl/core/signed_integer_to_radix_digits.sv
tb/signed_integer_to_radix_digits_tb.sv
